FILE: rtl/lsp2d_pkg.sv
package lsp2d_pkg;

  // request opcode
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  localparam int IDX_W  = 4;      // knot index field
  localparam int CNT_W  = 5;      // knot_count register
  localparam int T_W    = 18;     // t field, signed q2.16
  localparam int TC_W   = 17;     // clamped t, 0..1.0
  localparam int FRAC_W = 16;     // segment fraction
  localparam int T_ONE  = 65536;  // 1.0 in q2.16

endpackage

FILE: rtl/lsp2d_if.sv
interface lsp2d_in_if #(
  parameter int COORD_WIDTH = 24
);
  import lsp2d_pkg::*;

  logic                          valid;
  logic                          ready;
  op_t                           op;
  logic [IDX_W-1:0]              knot_index;
  logic signed [COORD_WIDTH-1:0] knot_x;
  logic signed [COORD_WIDTH-1:0] knot_y;
  logic signed [T_W-1:0]         t;

  modport source (output valid, op, knot_index, knot_x, knot_y, t, input ready);
  modport sink   (input valid, op, knot_index, knot_x, knot_y, t, output ready);
endinterface

interface lsp2d_out_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;

  modport source (output valid, x, y, input ready);
  modport sink   (input valid, x, y, output ready);
endinterface

FILE: rtl/lsp2d_ram.sv
module lsp2d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/linear_spline_2d_eval.sv
// 2d piecewise-linear spline over evenly spaced knots in t = 0..1. A load request
// (op = OP_LOAD) writes knot_x/knot_y into table entry knot_index and gives no result;
// indexes at or beyond MAX_KNOTS are dropped. An evaluate request (op = OP_EVAL) clamps
// t (signed q2.16) to 0..1.0, scales it by knot_count - 1, and returns x/y interpolated
// between the two neighboring knots, with the fractional product rounded toward minus
// infinity; t = 1.0 or a single knot returns the last knot exactly. knot_count is
// taken as 1 when written 0 and saturates at MAX_KNOTS; change it only while the block
// is empty. Evaluating a knot that was never loaded returns undefined data. The block
// takes one request per clock while out_chan.ready does not stall a full pipe; the
// six register stages (clamp, scale multiply, table read, difference, fraction
// multiply, add) each stall only when everything ahead of them is full, and loads
// update the table in request order with respect to evaluations.
module linear_spline_2d_eval #(
  parameter int MAX_KNOTS   = 16,
  parameter int COORD_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lsp2d_pkg::CNT_W-1:0]  cfg_wdata,
  lsp2d_in_if.sink                     in_chan,
  lsp2d_out_if.source                  out_chan
);
  import lsp2d_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);       // table address
  localparam int PW = TC_W + AW;               // scaled t
  localparam int DW = COORD_WIDTH + 1;         // knot difference
  localparam int MW = DW + FRAC_W + 1;         // difference times fraction
  localparam int CW = COORD_WIDTH;

  // configuration
  logic [CNT_W-1:0] knot_count_r;
  logic [AW-1:0]    nm1;  // knots in use minus one, after clamping

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      knot_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (knot_count_r == '0) begin
      nm1 = '0;
    end else if (32'(knot_count_r) > 32'(MAX_KNOTS)) begin
      nm1 = AW'(MAX_KNOTS - 1);
    end else begin
      nm1 = AW'(knot_count_r - CNT_W'(1));
    end
  end

  // stage valids and the ready chain, output end backwards
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_r || out_chan.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  // stage 1: capture, clamp t, qualify the load index
  logic [TC_W-1:0]      t_nxt;
  logic                 wr_ok_nxt;
  logic [TC_W-1:0]      t1_r;
  op_t                  op1_r;
  logic                 wr_ok1_r;
  logic [AW-1:0]        widx1_r;
  logic [2*CW-1:0]      wdata1_r;

  always_comb begin
    if (in_chan.t[T_W-1]) begin
      t_nxt = '0;
    end else if (in_chan.t[TC_W-1:0] > TC_W'(T_ONE)) begin
      t_nxt = TC_W'(T_ONE);
    end else begin
      t_nxt = in_chan.t[TC_W-1:0];
    end
    wr_ok_nxt = (in_chan.op == OP_LOAD) &&
                (32'(in_chan.knot_index) < 32'(MAX_KNOTS));
  end

  // stage 2: t scaled by the segment count
  op_t             op2_r;
  logic            wr_ok2_r;
  logic [AW-1:0]   widx2_r;
  logic [2*CW-1:0] wdata2_r;
  logic [PW-1:0]   prod2_r;

  // segment decode feeding the table read
  logic [AW-1:0]     seg;
  logic              at_end;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [FRAC_W-1:0] frac_nxt;
  logic              ram_we;

  always_comb begin
    seg    = prod2_r[FRAC_W +: AW];
    at_end = (seg >= nm1);
    if (at_end) begin
      // last knot, or the only one: both taps on it and no blend
      rd_addr_a = nm1;
      rd_addr_b = nm1;
      frac_nxt  = '0;
    end else begin
      rd_addr_a = seg;
      rd_addr_b = seg + AW'(1);
      frac_nxt  = prod2_r[FRAC_W-1:0];
    end
  end

  // a load writes the table as it leaves stage 2, so reads stay in request order
  assign ram_we = v2_r && wr_ok2_r && rdy3;

  // stage 3: knot pair from the table
  logic [2*CW-1:0]   rd_a, rd_b;
  logic [FRAC_W-1:0] frac3_r;

  lsp2d_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (widx2_r),
    .wdata   (wdata2_r),
    .re      (rdy3),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // stage 4: base knot and difference
  logic signed [CW-1:0] p0x4_r, p0y4_r;
  logic signed [DW-1:0] dx4_r, dy4_r;
  logic [FRAC_W-1:0]    frac4_r;

  // stage 5: difference times fraction
  logic signed [CW-1:0] p0x5_r, p0y5_r;
  logic signed [MW-1:0] mx5_r, my5_r;

  // stage 6: output register
  logic signed [CW-1:0] x6_r, y6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_chan.valid;
      if (rdy2) v2_r <= v1_r;
      // loads end here
      if (rdy3) v3_r <= v2_r && (op2_r == OP_EVAL);
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1_r     <= t_nxt;
      op1_r    <= in_chan.op;
      wr_ok1_r <= wr_ok_nxt;
      widx1_r  <= AW'(in_chan.knot_index);
      wdata1_r <= {in_chan.knot_x, in_chan.knot_y};
    end
    if (rdy2) begin
      op2_r    <= op1_r;
      wr_ok2_r <= wr_ok1_r;
      widx2_r  <= widx1_r;
      wdata2_r <= wdata1_r;
      prod2_r  <= PW'(t1_r) * PW'(nm1);
    end
    if (rdy3) begin
      frac3_r <= frac_nxt;
    end
    if (rdy4) begin
      p0x4_r  <= rd_a[2*CW-1:CW];
      p0y4_r  <= rd_a[CW-1:0];
      dx4_r   <= DW'(signed'(rd_b[2*CW-1:CW])) - DW'(signed'(rd_a[2*CW-1:CW]));
      dy4_r   <= DW'(signed'(rd_b[CW-1:0])) - DW'(signed'(rd_a[CW-1:0]));
      frac4_r <= frac3_r;
    end
    if (rdy5) begin
      p0x5_r <= p0x4_r;
      p0y5_r <= p0y4_r;
      mx5_r  <= MW'(dx4_r) * MW'(signed'({1'b0, frac4_r}));
      my5_r  <= MW'(dy4_r) * MW'(signed'({1'b0, frac4_r}));
    end
    if (rdy6) begin
      // arithmetic shift by the fraction width floors toward minus infinity
      x6_r <= p0x5_r + mx5_r[FRAC_W +: CW];
      y6_r <= p0y5_r + my5_r[FRAC_W +: CW];
    end
  end

  assign out_chan.valid = v6_r;
  assign out_chan.x     = x6_r;
  assign out_chan.y     = y6_r;

  // checks
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (op2_r == OP_EVAL) |-> (rd_addr_b <= nm1) && (rd_addr_a <= rd_addr_b))
    else $error("segment taps outside the knots in use");

  a_single_knot: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (op2_r == OP_EVAL) && (nm1 == '0) |->
      (frac_nxt == '0) && (rd_addr_a == '0) && (rd_addr_b == '0))
    else $error("single knot must read entry zero unblended");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy4 |=> v3_r && $stable(frac3_r) && $stable(rd_a) && $stable(rd_b))
    else $error("table read stage changed while stalled");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v6_r |-> in_chan.ready)
    else $error("input stalled with the output stage empty");

endmodule

FILE: test/tb_top.sv
module tb_top;
  import lsp2d_pkg::*;

  localparam int COORD_W     = 24;
  localparam int KNOTS       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int SETTLE      = 10;      // settle margin beyond the six-stage pipe
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  // one request on the input channel
  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] kx;
    logic signed [COORD_W-1:0] ky;
    logic signed [T_W-1:0]     t;
  } spline_req_t;

  // one evaluated point on the result channel
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // directed row: optional knot_count write first, then the request,
  // with the point typed in where it is obvious
  typedef struct packed {
    bit               cfg_en;
    logic [CNT_W-1:0] cfg;
    spline_req_t      rq;
    bit               typed;
    point_t           want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lsp2d_in_if  #(.COORD_WIDTH(COORD_W)) in_bus ();
  lsp2d_out_if #(.COORD_WIDTH(COORD_W)) out_bus ();

  linear_spline_2d_eval #(
    .MAX_KNOTS  (KNOTS),
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // predictor state: our own copy of the knot tables and of knot_count
  logic signed [COORD_W-1:0] knot_xs [KNOTS];
  logic signed [COORD_W-1:0] knot_ys [KNOTS];
  bit                        knot_loaded [KNOTS];
  logic [CNT_W-1:0]          knot_cnt;

  point_t      pending_points [$];  // points still owed by the block, oldest first
  point_t      oldest_point;
  script_row_t script [$];
  int          phase_cfg [PHASES] = '{16, 3, 31, 2, 0, 7, 17, 1};

  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // global watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // knot_count as the block uses it: zero means one, saturates at the table size
  function automatic int knots_in_use();
    int n;
    n = knot_cnt;
    if (n == 0) n = 1;
    if (n > KNOTS) n = KNOTS;
    return n;
  endfunction

  // p0 + floor((p1 - p0) * frac / 2^16), arithmetic shift gives the floor
  function automatic logic signed [COORD_W-1:0] blend_coord(
    logic signed [COORD_W-1:0] p0, logic signed [COORD_W-1:0] p1, longint frac);
    longint span;
    span = longint'(p1) - longint'(p0);
    return COORD_W'(longint'(p0) + ((span * frac) >>> FRAC_W));
  endfunction

  function automatic point_t eval_spline(logic signed [T_W-1:0] t);
    int     n;
    longint tc, prod, seg, frac;
    point_t p;
    n  = knots_in_use();
    tc = t;
    if (tc < 0) tc = 0;
    if (tc > T_ONE) tc = T_ONE;
    if (n == 1) begin
      p.x = knot_xs[0];
      p.y = knot_ys[0];
    end else begin
      prod = tc * (n - 1);
      seg  = prod >>> FRAC_W;
      frac = prod & ((1 << FRAC_W) - 1);
      if (seg >= n - 1) begin
        // t = 1.0 lands exactly on the last knot
        p.x = knot_xs[n-1];
        p.y = knot_ys[n-1];
      end else begin
        p.x = blend_coord(knot_xs[seg], knot_xs[seg+1], frac);
        p.y = blend_coord(knot_ys[seg], knot_ys[seg+1], frac);
      end
    end
    return p;
  endfunction

  function automatic script_row_t script_row(bit cfg_en, int cfg, op_t op, int idx,
                                             int kx, int ky, int t,
                                             bit typed, int wx, int wy);
    script_row_t r;
    r.cfg_en = cfg_en;
    r.cfg    = CNT_W'(cfg);
    r.rq.op  = op;
    r.rq.idx = IDX_W'(idx);
    r.rq.kx  = COORD_W'(kx);
    r.rq.ky  = COORD_W'(ky);
    r.rq.t   = T_W'(t);
    r.typed  = typed;
    r.want.x = COORD_W'(wx);
    r.want.y = COORD_W'(wy);
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(script_row_t r);
    script.insert(script.size(), r);
  endfunction

  // mostly full-range values, with the extremes and small values mixed in
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return COORD_W'(int'($urandom_range(512)) - 256);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // random request; evaluations only once every knot in use holds a value,
  // until then the missing knots get loaded first
  function automatic spline_req_t gen_request();
    spline_req_t rq;
    int          n, hole, k, v;
    n    = knots_in_use();
    hole = -1;
    for (k = n - 1; k >= 0; k--)
      if (!knot_loaded[k]) hole = k;
    rq.op  = OP_LOAD;
    rq.idx = IDX_W'($urandom);
    rq.kx  = rand_coord();
    rq.ky  = rand_coord();
    rq.t   = T_W'($urandom);
    if (hole >= 0) begin
      rq.idx = IDX_W'(hole);
    end else if ($urandom_range(99) >= 25) begin
      rq.op = OP_EVAL;
      case ($urandom_range(5))
        0: v = int'($urandom);                  // whole field, clamps both ways
        1: v = int'($urandom_range(T_ONE, 0));
        2: begin                                // around a knot position
          k = $urandom_range(n - 1, 0);
          v = (k * T_ONE) / ((n > 1) ? n - 1 : 1) + int'($urandom_range(4, 0)) - 2;
        end
        3: begin
          case ($urandom_range(6))
            0:       v = 0;
            1:       v = T_ONE;
            2:       v = -1;
            3:       v = T_ONE - 1;
            4:       v = T_ONE + 1;
            5:       v = -(1 << (T_W - 1));
            default: v = (1 << (T_W - 1)) - 1;
          endcase
        end
        default: v = int'($urandom_range(T_ONE - 1, 1));
      endcase
      rq.t = T_W'(v);
    end
    return rq;
  endfunction

  // present one request, hold it until accepted, then update the prediction
  task automatic send_request(input spline_req_t rq, input bit typed, input point_t want);
    in_bus.valid      <= 1'b1;
    in_bus.op         <= rq.op;
    in_bus.knot_index <= rq.idx;
    in_bus.knot_x     <= rq.kx;
    in_bus.knot_y     <= rq.ky;
    in_bus.t          <= rq.t;
    do @(posedge clk); while (!in_bus.ready);
    if (rq.op == OP_LOAD) begin
      knot_xs[rq.idx]     = rq.kx;
      knot_ys[rq.idx]     = rq.ky;
      knot_loaded[rq.idx] = 1'b1;
    end else begin
      pending_points.insert(pending_points.size(), typed ? want : eval_spline(rq.t));
    end
  endtask

  // random gap between requests; with drain set, hold off until every point is back
  task automatic pause_sender(input bit drain);
    if (drain || $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk);
      while ((drain && pending_points.size() != 0) || $urandom_range(99) < send_idle_pct);
    end
  endtask

  // knot_count changes only with the pipe empty; loads leave no result behind,
  // so let the pipe run dry before the write
  task automatic set_knot_count(input int cnt);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(cnt);
    @(posedge clk);
    cfg_we    <= 1'b0;
    knot_cnt   = CNT_W'(cnt);
  endtask

  // result side: check against the oldest owed point, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_points.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected point, expected none, got x=%h y=%h",
                 $time, out_bus.x, out_bus.y);
      end else begin
        oldest_point = pending_points.pop_front();
        if (out_bus.x !== oldest_point.x || out_bus.y !== oldest_point.y) begin
          fail_cnt++;
          $display("%0t: point mismatch, expected x=%h y=%h, got x=%h y=%h", $time,
                   oldest_point.x, oldest_point.y, out_bus.x, out_bus.y);
        end
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int row, ph, item;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.op         <= OP_LOAD;
    in_bus.knot_index <= '0;
    in_bus.knot_x     <= '0;
    in_bus.knot_y     <= '0;
    in_bus.t          <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    knot_cnt       = CNT_W'(1);  // reset value of knot_count

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; knot 0 = (max, min), knot 1 = (min, max), knot 15 = (0abcde, -1)
    // single knot after reset: every t returns knot 0
    add_row(script_row(0, 0, OP_LOAD, 0, C_MAX, C_MIN, 0, 0, 0, 0));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, 0, 1, C_MAX, C_MIN));
    // most negative t, clamped to zero
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, -131072, 1, C_MAX, C_MIN));
    // knot_count of zero acts as one knot
    add_row(script_row(1, 0, OP_EVAL, 0, 0, 0, 131071, 1, C_MAX, C_MIN));
    // loads carry a stray t that must not matter
    add_row(script_row(0, 0, OP_LOAD, 1, C_MIN, C_MAX, 131071, 0, 0, 0));
    add_row(script_row(0, 0, OP_LOAD, 15, 'h0ABCDE, -1, 0, 0, 0, 0));
    // two knots: the ends, the middle with the widest span, near the ends
    add_row(script_row(1, 2, OP_EVAL, 0, 0, 0, 0, 1, C_MAX, C_MIN));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, T_ONE, 1, C_MIN, C_MAX));
    add_row(script_row(0, 0, OP_EVAL, 15, C_MIN, C_MAX, 32768, 0, 0, 0));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, 1, 0, 0, 0));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, T_ONE - 1, 0, 0, 0));
    // t just outside 0..1.0 on either side
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, -1, 1, C_MAX, C_MIN));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, T_ONE + 1, 1, C_MIN, C_MAX));
    // full table and saturated counts only touch the last knot at t >= 1.0
    add_row(script_row(1, 16, OP_EVAL, 0, 0, 0, T_ONE, 1, 'h0ABCDE, -1));
    add_row(script_row(1, 31, OP_EVAL, 0, 0, 0, 131071, 1, 'h0ABCDE, -1));
    add_row(script_row(0, 0, OP_EVAL, 0, 0, 0, T_ONE, 1, 'h0ABCDE, -1));
    add_row(script_row(1, 17, OP_EVAL, 0, 0, 0, 70000, 1, 'h0ABCDE, -1));
    // three knots, second segment
    add_row(script_row(0, 0, OP_LOAD, 2, 0, 0, 0, 0, 0, 0));
    add_row(script_row(1, 3, OP_EVAL, 0, 0, 0, 32768, 0, 0, 0));
    add_row(script_row(1, 1, OP_EVAL, 0, 0, 0, 40000, 1, C_MAX, C_MIN));

    for (row = 0; row < script.size(); row++) begin
      if (script[row].cfg_en)
        set_knot_count(script[row].cfg);
      else if (row > 0)
        pause_sender(1'b0);
      send_request(script[row].rq, script[row].typed, script[row].want);
    end

    // random phases: new knot_count each phase, pacing cycles through four modes
    for (ph = 0; ph < PHASES; ph++) begin
      set_knot_count(phase_cfg[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (item = 0; item < PHASE_ITEMS; item++) begin
        // once, mid-phase, let everything drain before sending on
        pause_sender(ph == 1 && item == PHASE_ITEMS / 2);
        send_request(gen_request(), 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lsp2d_pkg.sv
rtl/lsp2d_if.sv
rtl/lsp2d_ram.sv
rtl/linear_spline_2d_eval.sv
test/tb_top.sv
